FILE: hw/rtl/lobe_pkg.sv
`default_nettype none
package lobe_pkg;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_CANCEL  = 3'd1,
    OP_MODIFY  = 3'd2,
    OP_EXECUTE = 3'd3,
    OP_REPLACE = 3'd4,
    OP_CLEAR   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STS_APPLIED = 2'd0,
    STS_IGNORED = 2'd1,
    STS_ANOMALY = 2'd2,
    STS_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    LVL_NONE,
    LVL_ADD,
    LVL_SUB
  } lvl_kind_e;

  typedef enum logic [1:0] {
    TBL_NONE,
    TBL_APPEND,
    TBL_UPDATE,
    TBL_REMOVE
  } tbl_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SUB,
    S_ADD,
    S_COMMIT,
    S_FIND
  } state_e;

  localparam int unsigned PRICE_W = 32;
  localparam int unsigned REM_W   = 31;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned TOTAL_W = 48;

  typedef struct packed {
    lvl_kind_e            kind;
    logic [PRICE_W-1:0]   price;
    logic [REM_W-1:0]     amount;
    logic                 drop;
  } lvl_cmd_t;

  typedef struct packed {
    tbl_kind_e            kind;
    logic [KEY_W-1:0]     key;
    logic                 side;
    logic [PRICE_W-1:0]   price;
    logic [REM_W-1:0]     rem;
  } tbl_cmd_t;

  typedef struct packed {
    logic                 hit;
    logic                 side;
    logic [PRICE_W-1:0]   price;
    logic [REM_W-1:0]     rem;
  } look_t;

endpackage
`default_nettype wire

FILE: hw/rtl/limit_order_book_engine_unit.sv
`default_nettype none
// Each taken order event passes through S_LOOK, S_SUB, S_ADD, S_COMMIT and S_FIND, with
// busy_o high in each (one order lookup, one level reduction, one level insertion, one
// table write, one final lookup); done_o marks the result for exactly one cycle, in
// which a new event may already start; the receiver cannot stall. The order table and
// both price ladders are rows of cells that compare in parallel and shift on removal, the
// ladders also on insertion, so clearing is immediate and needs no sweep after reset.
module limit_order_book_engine_unit #(
  parameter int unsigned ORDER_SLOTS = 1024,
  parameter int unsigned LEVEL_SLOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         operation_i,
  input  logic [63:0]        order_id_i,
  input  logic [63:0]        new_order_id_i,
  input  logic               side_i,
  input  logic [31:0]        price_i,
  input  logic signed [31:0] quantity_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic               bid_valid_o,
  output logic [31:0]        bid_price_o,
  output logic [47:0]        bid_total_o,
  output logic               ask_valid_o,
  output logic [31:0]        ask_price_o,
  output logic [47:0]        ask_total_o,
  output logic [30:0]        order_left_o
);
  import lobe_pkg::*;

  localparam int unsigned IW    = $clog2(ORDER_SLOTS);
  localparam int unsigned ORD_W = $clog2(ORDER_SLOTS + 1);

  state_e state_q, state_d;

  logic [2:0]         op_q;
  logic [KEY_W-1:0]   id_q, nid_q;
  logic               side_q;
  logic [PRICE_W-1:0] price_q;
  logic [31:0]        qty_q;

  logic               hit_q, nhit_q, hside_q;
  logic [IW-1:0]      idx_q;
  logic [PRICE_W-1:0] hprice_q;
  logic [REM_W-1:0]   hrem_q;

  logic               add_en_q, add_side_q, add_ok_q, anom_q;
  tbl_kind_e          ok_kind_q, fail_kind_q;
  logic [KEY_W-1:0]   tkey_q;
  logic [PRICE_W-1:0] tprice_q;
  logic [REM_W-1:0]   trem_q;
  logic               tside_q;
  status_e            sts_q, fin_sts_q;

  logic [47:0]        event_cnt_q;
  logic [31:0]        anomaly_cnt_q;
  logic [31:0]        clear_cnt_q;

  logic               done_q;
  logic [1:0]         status_out_q;
  logic               bid_valid_q, ask_valid_q;
  logic [31:0]        bid_price_q, ask_price_q;
  logic [47:0]        bid_total_q, ask_total_q;
  logic [30:0]        left_q;

  logic               qpos;
  logic [REM_W-1:0]   qv;

  logic               sub_en, sub_drop, add_en, add_side, anom;
  logic [REM_W-1:0]   sub_amt, trem;
  tbl_kind_e          ok_kind, fail_kind;
  logic [KEY_W-1:0]   tkey;
  logic [PRICE_W-1:0] tprice;
  logic               tside;
  status_e            sts;

  logic [KEY_W-1:0]   key_a;
  look_t              look_a;
  logic [IW-1:0]      idx_a;
  logic               hit_b, tbl_full;
  tbl_cmd_t           tbl_cmd;
  logic               clear_now;
  lvl_cmd_t           lvl_cmd, bid_cmd, ask_cmd;
  logic               bid_ok, ask_ok;
  logic               bid_v, ask_v;
  logic [31:0]        bid_p, ask_p;
  logic [47:0]        bid_t, ask_t;
  logic               add_failed;

  assign qpos = !qty_q[31] && (qty_q[30:0] != '0);
  assign qv   = qty_q[30:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (start_i) state_d = S_LOOK;
      S_LOOK:   state_d = S_SUB;
      S_SUB:    state_d = S_ADD;
      S_ADD:    state_d = S_COMMIT;
      S_COMMIT: state_d = S_FIND;
      S_FIND:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    sub_en    = 1'b0;
    sub_drop  = 1'b1;
    sub_amt   = hrem_q;
    add_en    = 1'b0;
    add_side  = hside_q;
    ok_kind   = TBL_NONE;
    fail_kind = TBL_NONE;
    tkey      = id_q;
    tprice    = hprice_q;
    trem      = hrem_q;
    tside     = side_q;
    sts       = STS_APPLIED;
    anom      = 1'b0;
    case (op_q)
      OP_ADD: begin
        if (!qpos) begin
          sts = STS_IGNORED;
        end else if (hit_q) begin
          sts  = STS_ANOMALY;
          anom = 1'b1;
        end else if (tbl_full) begin
          sts = STS_FULL;
        end else begin
          add_en   = 1'b1;
          add_side = side_q;
          ok_kind  = TBL_APPEND;
          tprice   = price_q;
          trem     = qv;
        end
      end
      OP_CLEAR: begin
        sts = STS_APPLIED;
      end
      OP_CANCEL, OP_MODIFY, OP_EXECUTE, OP_REPLACE: begin
        if (!hit_q) begin
          sts  = STS_ANOMALY;
          anom = 1'b1;
        end else begin
          case (op_q)
            OP_CANCEL: begin
              sub_en = 1'b1;
              if (!qpos || qv >= hrem_q) begin
                ok_kind = TBL_REMOVE;
              end else begin
                sub_drop = 1'b0;
                sub_amt  = qv;
                ok_kind  = TBL_UPDATE;
                trem     = hrem_q - qv;
              end
            end
            OP_EXECUTE: begin
              if (!qpos) begin
                sts = STS_IGNORED;
              end else if (qv >= hrem_q) begin
                sub_en  = 1'b1;
                ok_kind = TBL_REMOVE;
              end else begin
                sub_en   = 1'b1;
                sub_drop = 1'b0;
                sub_amt  = qv;
                ok_kind  = TBL_UPDATE;
                trem     = hrem_q - qv;
              end
            end
            OP_MODIFY: begin
              if (!qpos) begin
                sub_en  = 1'b1;
                ok_kind = TBL_REMOVE;
              end else if (price_q == hprice_q && qv <= hrem_q) begin
                if (qv == hrem_q) begin
                  sts = STS_IGNORED;
                end else begin
                  sub_en   = 1'b1;
                  sub_drop = 1'b0;
                  sub_amt  = hrem_q - qv;
                  ok_kind  = TBL_UPDATE;
                  trem     = qv;
                end
              end else begin
                sub_en    = 1'b1;
                add_en    = 1'b1;
                ok_kind   = TBL_UPDATE;
                fail_kind = TBL_REMOVE;
                tprice    = price_q;
                trem      = qv;
              end
            end
            default: begin
              sub_en = 1'b1;
              if (!qpos) begin
                ok_kind = TBL_REMOVE;
              end else if (nhit_q && nid_q != id_q) begin
                ok_kind = TBL_REMOVE;
                sts     = STS_ANOMALY;
                anom    = 1'b1;
              end else begin
                add_en    = 1'b1;
                ok_kind   = TBL_UPDATE;
                fail_kind = TBL_REMOVE;
                tkey      = nid_q;
                tprice    = price_q;
                trem      = qv;
              end
            end
          endcase
        end
      end
      default: begin
        sts = STS_IGNORED;
      end
    endcase
  end

  assign add_failed = add_en_q && !add_ok_q;
  assign clear_now  = (state_q == S_COMMIT) && (op_q == OP_CLEAR);

  always_comb begin
    busy_o        = (state_q != S_IDLE);
    key_a         = id_q;
    lvl_cmd       = '0;
    lvl_cmd.kind  = LVL_NONE;
    bid_cmd       = '0;
    bid_cmd.kind  = LVL_NONE;
    ask_cmd       = '0;
    ask_cmd.kind  = LVL_NONE;
    tbl_cmd       = '0;
    tbl_cmd.kind  = TBL_NONE;
    case (state_q)
      S_SUB: begin
        lvl_cmd.kind   = sub_en ? LVL_SUB : LVL_NONE;
        lvl_cmd.price  = hprice_q;
        lvl_cmd.amount = sub_amt;
        lvl_cmd.drop   = sub_drop;
        if (hside_q) ask_cmd = lvl_cmd;
        else         bid_cmd = lvl_cmd;
      end
      S_ADD: begin
        lvl_cmd.kind   = add_en_q ? LVL_ADD : LVL_NONE;
        lvl_cmd.price  = price_q;
        lvl_cmd.amount = qv;
        lvl_cmd.drop   = 1'b0;
        if (add_side_q) ask_cmd = lvl_cmd;
        else            bid_cmd = lvl_cmd;
      end
      S_COMMIT: begin
        tbl_cmd.kind  = add_failed ? fail_kind_q : ok_kind_q;
        tbl_cmd.key   = tkey_q;
        tbl_cmd.side  = tside_q;
        tbl_cmd.price = tprice_q;
        tbl_cmd.rem   = trem_q;
      end
      S_FIND: begin
        key_a = (op_q == OP_REPLACE) ? nid_q : id_q;
      end
      default: begin
        key_a = id_q;
      end
    endcase
  end

  lobe_ord_table #(
    .SLOTS (ORDER_SLOTS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (clear_now),
    .key_a_i   (key_a),
    .key_b_i   (nid_q),
    .look_a_o  (look_a),
    .idx_a_o   (idx_a),
    .hit_b_o   (hit_b),
    .full_o    (tbl_full),
    .cmd_i     (tbl_cmd),
    .cmd_idx_i (idx_q)
  );

  lobe_ladder #(
    .LEVELS (LEVEL_SLOTS),
    .ORD_W  (ORD_W),
    .ASK    (1'b0)
  ) u_bid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (clear_now),
    .cmd_i        (bid_cmd),
    .add_ok_o     (bid_ok),
    .best_valid_o (bid_v),
    .best_price_o (bid_p),
    .best_total_o (bid_t)
  );

  lobe_ladder #(
    .LEVELS (LEVEL_SLOTS),
    .ORD_W  (ORD_W),
    .ASK    (1'b1)
  ) u_ask (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (clear_now),
    .cmd_i        (ask_cmd),
    .add_ok_o     (ask_ok),
    .best_valid_o (ask_v),
    .best_price_o (ask_p),
    .best_total_o (ask_t)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      op_q    <= operation_i;
      id_q    <= order_id_i;
      nid_q   <= new_order_id_i;
      side_q  <= side_i;
      price_q <= price_i;
      qty_q   <= quantity_i;
    end
    if (state_q == S_LOOK) begin
      hit_q    <= look_a.hit;
      hside_q  <= look_a.side;
      hprice_q <= look_a.price;
      hrem_q   <= look_a.rem;
      idx_q    <= idx_a;
      nhit_q   <= hit_b;
    end
    if (state_q == S_SUB) begin
      add_en_q    <= add_en;
      add_side_q  <= add_side;
      ok_kind_q   <= ok_kind;
      fail_kind_q <= fail_kind;
      tkey_q      <= tkey;
      tprice_q    <= tprice;
      trem_q      <= trem;
      tside_q     <= tside;
      sts_q       <= sts;
      anom_q      <= anom;
    end
    if (state_q == S_ADD) begin
      add_ok_q <= add_side_q ? ask_ok : bid_ok;
    end
    if (state_q == S_COMMIT) begin
      fin_sts_q <= add_failed ? STS_FULL : sts_q;
    end
    if (state_q == S_FIND) begin
      status_out_q <= fin_sts_q;
      bid_valid_q  <= bid_v;
      bid_price_q  <= bid_p;
      bid_total_q  <= bid_t;
      ask_valid_q  <= ask_v;
      ask_price_q  <= ask_p;
      ask_total_q  <= ask_t;
      left_q       <= look_a.hit ? look_a.rem : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      done_q        <= 1'b0;
      event_cnt_q   <= '0;
      anomaly_cnt_q <= '0;
      clear_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_FIND);
      if (state_q == S_COMMIT) begin
        if (op_q <= OP_CLEAR) begin
          event_cnt_q <= event_cnt_q + 48'd1;
        end
        if (anom_q) begin
          anomaly_cnt_q <= anomaly_cnt_q + 32'd1;
        end
        if (op_q == OP_CLEAR) begin
          clear_cnt_q <= clear_cnt_q + 32'd1;
        end
      end
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_out_q;
  assign bid_valid_o  = bid_valid_q;
  assign bid_price_o  = bid_price_q;
  assign bid_total_o  = bid_total_q;
  assign ask_valid_o  = ask_valid_q;
  assign ask_price_o  = ask_price_q;
  assign ask_total_o  = ask_total_q;
  assign order_left_o = left_q;

endmodule
`default_nettype wire

FILE: hw/rtl/lobe_ord_table.sv
`default_nettype none
module lobe_ord_table #(
  parameter int unsigned SLOTS = 1024,
  localparam int unsigned IW = $clog2(SLOTS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clear_i,
  input  logic [63:0]            key_a_i,
  input  logic [63:0]            key_b_i,
  output lobe_pkg::look_t        look_a_o,
  output logic [IW-1:0]          idx_a_o,
  output logic                   hit_b_o,
  output logic                   full_o,
  input  lobe_pkg::tbl_cmd_t     cmd_i,
  input  logic [IW-1:0]          cmd_idx_i
);
  import lobe_pkg::*;

  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic [KEY_W-1:0]   key_q   [SLOTS];
  logic [KEY_W-1:0]   key_d   [SLOTS];
  logic               side_q  [SLOTS];
  logic               side_d  [SLOTS];
  logic [PRICE_W-1:0] price_q [SLOTS];
  logic [PRICE_W-1:0] price_d [SLOTS];
  logic [REM_W-1:0]   rem_q   [SLOTS];
  logic [REM_W-1:0]   rem_d   [SLOTS];
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [SLOTS-1:0]   live, match_a, match_b;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      live[i]    = CW'(i) < cnt_q;
      match_a[i] = live[i] && (key_q[i] == key_a_i);
      match_b[i] = live[i] && (key_q[i] == key_b_i);
    end
  end

  always_comb begin
    look_a_o = '0;
    idx_a_o  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match_a[i]) begin
        look_a_o.hit   = 1'b1;
        look_a_o.side  = look_a_o.side | side_q[i];
        look_a_o.price = look_a_o.price | price_q[i];
        look_a_o.rem   = look_a_o.rem | rem_q[i];
        idx_a_o        = idx_a_o | IW'(i);
      end
    end
  end

  assign hit_b_o = |match_b;
  assign full_o  = (cnt_q == CW'(SLOTS));

  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < SLOTS; i++) begin
      key_d[i]   = key_q[i];
      side_d[i]  = side_q[i];
      price_d[i] = price_q[i];
      rem_d[i]   = rem_q[i];
    end
    if (clear_i) begin
      cnt_d = '0;
    end else begin
      case (cmd_i.kind)
        TBL_APPEND: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (CW'(i) == cnt_q) begin
              key_d[i]   = cmd_i.key;
              side_d[i]  = cmd_i.side;
              price_d[i] = cmd_i.price;
              rem_d[i]   = cmd_i.rem;
            end
          end
          cnt_d = cnt_q + CW'(1);
        end
        TBL_UPDATE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (IW'(i) == cmd_idx_i) begin
              key_d[i]   = cmd_i.key;
              price_d[i] = cmd_i.price;
              rem_d[i]   = cmd_i.rem;
            end
          end
        end
        TBL_REMOVE: begin
          for (int i = 0; i < SLOTS - 1; i++) begin
            if (IW'(i) >= cmd_idx_i) begin
              key_d[i]   = key_q[i+1];
              side_d[i]  = side_q[i+1];
              price_d[i] = price_q[i+1];
              rem_d[i]   = rem_q[i+1];
            end
          end
          cnt_d = cnt_q - CW'(1);
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOTS; i++) begin
      key_q[i]   <= key_d[i];
      side_q[i]  <= side_d[i];
      price_q[i] <= price_d[i];
      rem_q[i]   <= rem_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lobe_ladder.sv
`default_nettype none
module lobe_ladder #(
  parameter int unsigned LEVELS = 64,
  parameter int unsigned ORD_W  = 11,
  parameter bit          ASK    = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  lobe_pkg::lvl_cmd_t  cmd_i,
  output logic                add_ok_o,
  output logic                best_valid_o,
  output logic [31:0]         best_price_o,
  output logic [47:0]         best_total_o
);
  import lobe_pkg::*;

  localparam int unsigned UW = $clog2(LEVELS + 1);

  logic [PRICE_W-1:0] price_q  [LEVELS];
  logic [PRICE_W-1:0] price_d  [LEVELS];
  logic [TOTAL_W-1:0] total_q  [LEVELS];
  logic [TOTAL_W-1:0] total_d  [LEVELS];
  logic [ORD_W-1:0]   orders_q [LEVELS];
  logic [ORD_W-1:0]   orders_d [LEVELS];
  logic [UW-1:0]      used_q, used_d;

  logic [LEVELS-1:0]  live, hit, goes_ahead, at_after;
  logic               found, room, empty;
  logic [TOTAL_W-1:0] sel_total, add_total, sub_total;
  logic [ORD_W-1:0]   sel_orders, sub_orders;
  logic [TOTAL_W:0]   sum;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      live[i] = UW'(i) < used_q;
      hit[i]  = live[i] && (price_q[i] == cmd_i.price);
      if (ASK) begin
        goes_ahead[i] = !live[i] || (cmd_i.price < price_q[i]);
        at_after[i]   = live[i] && (price_q[i] >= cmd_i.price);
      end else begin
        goes_ahead[i] = !live[i] || (cmd_i.price > price_q[i]);
        at_after[i]   = live[i] && (price_q[i] <= cmd_i.price);
      end
    end
  end

  always_comb begin
    sel_total  = '0;
    sel_orders = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (hit[i]) begin
        sel_total  = sel_total | total_q[i];
        sel_orders = sel_orders | orders_q[i];
      end
    end
  end

  assign found     = |hit;
  assign room      = (used_q != UW'(LEVELS));
  assign add_ok_o  = found || room;
  assign sum       = {1'b0, sel_total} + (TOTAL_W + 1)'(cmd_i.amount);
  assign add_total = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
  assign sub_total = (sel_total > TOTAL_W'(cmd_i.amount)) ?
                     (sel_total - TOTAL_W'(cmd_i.amount)) : '0;
  assign sub_orders = (cmd_i.drop && (sel_orders != '0)) ? (sel_orders - ORD_W'(1)) :
                      sel_orders;
  assign empty      = (sub_orders == '0);

  always_comb begin
    used_d = used_q;
    for (int i = 0; i < LEVELS; i++) begin
      price_d[i]  = price_q[i];
      total_d[i]  = total_q[i];
      orders_d[i] = orders_q[i];
    end
    if (clear_i) begin
      used_d = '0;
    end else begin
      case (cmd_i.kind)
        LVL_ADD: begin
          if (found) begin
            for (int i = 0; i < LEVELS; i++) begin
              if (hit[i]) begin
                total_d[i]  = add_total;
                orders_d[i] = sel_orders + ORD_W'(1);
              end
            end
          end else if (room) begin
            if (goes_ahead[0]) begin
              price_d[0]  = cmd_i.price;
              total_d[0]  = TOTAL_W'(cmd_i.amount);
              orders_d[0] = ORD_W'(1);
            end
            for (int i = 1; i < LEVELS; i++) begin
              if (goes_ahead[i-1]) begin
                price_d[i]  = price_q[i-1];
                total_d[i]  = total_q[i-1];
                orders_d[i] = orders_q[i-1];
              end else if (goes_ahead[i]) begin
                price_d[i]  = cmd_i.price;
                total_d[i]  = TOTAL_W'(cmd_i.amount);
                orders_d[i] = ORD_W'(1);
              end
            end
            used_d = used_q + UW'(1);
          end
        end
        LVL_SUB: begin
          if (found) begin
            if (empty) begin
              for (int i = 0; i < LEVELS - 1; i++) begin
                if (at_after[i]) begin
                  price_d[i]  = price_q[i+1];
                  total_d[i]  = total_q[i+1];
                  orders_d[i] = orders_q[i+1];
                end
              end
              used_d = used_q - UW'(1);
            end else begin
              for (int i = 0; i < LEVELS; i++) begin
                if (hit[i]) begin
                  total_d[i]  = sub_total;
                  orders_d[i] = sub_orders;
                end
              end
            end
          end
        end
        default: begin
          used_d = used_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LEVELS; i++) begin
      price_q[i]  <= price_d[i];
      total_q[i]  <= total_d[i];
      orders_q[i] <= orders_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  assign best_valid_o = (used_q != '0);
  assign best_price_o = best_valid_o ? price_q[0] : '0;
  assign best_total_o = best_valid_o ? total_q[0] : '0;

endmodule
`default_nettype wire
